@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Check that an expression is never true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

@@ rtl/core/jse_pkg.sv @@
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, constants and helpers of the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

  // Request kinds on the input channel
  typedef enum logic [1:0] {
    KIND_UNIT  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } item_kind_e;

  // Escape option bits
  localparam int unsigned OPT_W        = 6;
  localparam int unsigned OPT_HEX_QUOT = 0;
  localparam int unsigned OPT_NO_SLASH = 1;
  localparam int unsigned OPT_HEX_TAG  = 2;
  localparam int unsigned OPT_HEX_AMP  = 3;
  localparam int unsigned OPT_HEX_APOS = 4;
  localparam int unsigned OPT_EXTRA    = 5;

  // Register file layout
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;
  localparam logic        REG_IDX_OPTS = 1'b0;

  // Output run buffer
  localparam int unsigned RUN_MAX = 7;
  localparam int unsigned RUN_IW  = $clog2(RUN_MAX);
  localparam int unsigned RUN_LW  = $clog2(RUN_MAX + 1);

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // One classified request: the bytes to emit, first byte at index 0
  typedef struct packed {
    logic [0:RUN_MAX-1][7:0] bytes;
    logic [RUN_LW-1:0]       len;
    logic                    discard;
  } run_desc_t;

  // Lowercase hex digit of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

@@ rtl/core/jse_front.sv @@
// ----------------------------------------------------------------------------
// jse_front
// Accepts requests, tracks the open string and turns each request into a
// run of output bytes for the back end.
// ----------------------------------------------------------------------------
module jse_front import jse_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [OPT_W-1:0] opts_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       item_kind_i,
  input  logic [15:0]      code_unit_i,
  input  logic             q_full_i,
  output logic             push_o,
  output run_desc_t        push_desc_o
);

  logic             open_q, open_d;
  logic             accept;
  logic             has_quote;
  logic             use_run;
  logic [0:5][7:0]  body;
  logic [2:0]       body_len;
  logic             discard;
  logic [15:0]      u;

  assign u          = code_unit_i;
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Escape one code unit into at most six bytes
  always_comb begin
    body     = '0;
    body_len = 3'd1;
    case (u)
      16'h0022: begin
        if (opts_i[OPT_HEX_QUOT]) begin
          body = "\\u0022"; body_len = 3'd6;
        end else begin
          body = {"\\\"", 32'd0}; body_len = 3'd2;
        end
      end
      16'h005C: begin body = {"\\\\", 32'd0}; body_len = 3'd2; end
      16'h002F: begin
        if (opts_i[OPT_NO_SLASH]) begin
          body = {"/", 40'd0}; body_len = 3'd1;
        end else begin
          body = {"\\/", 32'd0}; body_len = 3'd2;
        end
      end
      16'h0008: begin body = {"\\b", 32'd0}; body_len = 3'd2; end
      16'h000C: begin body = {"\\f", 32'd0}; body_len = 3'd2; end
      16'h000A: begin body = {"\\n", 32'd0}; body_len = 3'd2; end
      16'h000D: begin body = {"\\r", 32'd0}; body_len = 3'd2; end
      16'h0009: begin body = {"\\t", 32'd0}; body_len = 3'd2; end
      16'h003C: begin
        if (opts_i[OPT_HEX_TAG] || opts_i[OPT_EXTRA]) begin
          body = "\\u003C"; body_len = 3'd6;
        end else begin
          body = {"<", 40'd0}; body_len = 3'd1;
        end
      end
      16'h003E: begin
        if (opts_i[OPT_HEX_TAG]) begin
          body = "\\u003E"; body_len = 3'd6;
        end else begin
          body = {">", 40'd0}; body_len = 3'd1;
        end
      end
      16'h0026: begin
        if (opts_i[OPT_HEX_AMP]) begin
          body = "\\u0026"; body_len = 3'd6;
        end else begin
          body = {"&", 40'd0}; body_len = 3'd1;
        end
      end
      16'h0027: begin
        if (opts_i[OPT_HEX_APOS]) begin
          body = "\\u0027"; body_len = 3'd6;
        end else begin
          body = {"'", 40'd0}; body_len = 3'd1;
        end
      end
      16'h0040: begin
        if (opts_i[OPT_EXTRA]) begin
          body = "\\u0040"; body_len = 3'd6;
        end else begin
          body = {"@", 40'd0}; body_len = 3'd1;
        end
      end
      16'h0025: begin
        if (opts_i[OPT_EXTRA]) begin
          body = "\\u0025"; body_len = 3'd6;
        end else begin
          body = {"%", 40'd0}; body_len = 3'd1;
        end
      end
      default: begin
        if (u inside {[16'h0020:16'h007F]}) begin
          body     = {u[7:0], 40'd0};
          body_len = 3'd1;
        end else begin
          body     = {"\\u", hex_char(u[15:12]), hex_char(u[11:8]),
                      hex_char(u[7:4]), hex_char(u[3:0])};
          body_len = 3'd6;
        end
      end
    endcase
  end

  // Classify the request and track the open string
  always_comb begin
    open_d    = open_q;
    has_quote = 1'b0;
    use_run   = 1'b1;
    discard   = 1'b0;
    push_desc_o = '0;
    case (item_kind_i)
      KIND_UNIT: begin
        has_quote = !open_q;
        open_d    = 1'b1;
        push_desc_o.len = RUN_LW'(body_len) + RUN_LW'(has_quote);
        if (has_quote) begin
          push_desc_o.bytes = {"\"", body};
        end else begin
          push_desc_o.bytes = {body, 8'd0};
        end
      end
      KIND_END: begin
        open_d = 1'b0;
        if (open_q) begin
          push_desc_o.bytes = {"\"", 48'd0};
          push_desc_o.len   = RUN_LW'(1);
        end else begin
          push_desc_o.bytes = {"\"\"", 40'd0};
          push_desc_o.len   = RUN_LW'(2);
        end
      end
      KIND_ERROR: begin
        open_d  = 1'b0;
        discard = 1'b1;
        push_desc_o.bytes = {"null", 24'd0};
        push_desc_o.len   = RUN_LW'(4);
      end
      default: begin
        use_run = 1'b0;
      end
    endcase
    push_desc_o.discard = discard;
  end

  assign push_o = accept && use_run;

  // Hold the open-string flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else if (accept) begin
      open_q <= open_d;
    end
  end

endmodule

@@ rtl/core/jse_queue.sv @@
// ----------------------------------------------------------------------------
// jse_queue
// Small descriptor queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jse_queue import jse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  run_desc_t push_desc_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output run_desc_t head_o
);

  run_desc_t           mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_q, wptr_d;
  logic [QUEUE_AW-1:0] rptr_q, rptr_d;
  logic [QUEUE_CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  // Advance pointers and the fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store pushed descriptors
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_desc_i;
    end
  end

  `ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o && !pop_i, "push into full queue")
  `ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")

endmodule

@@ rtl/core/jse_back.sv @@
// ----------------------------------------------------------------------------
// jse_back
// Walks the head descriptor and emits one byte per cycle, while the receiver
// is ready, through a registered output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jse_back import jse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  run_desc_t  head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       discard_before_o,
  output logic       last_of_run_o
);

  logic              valid_q, valid_d;
  logic [7:0]        byte_q;
  logic              disc_q;
  logic              last_q;
  logic [RUN_IW-1:0] idx_q, idx_d;
  logic              load;
  logic              take;
  logic              is_last;

  assign load    = !valid_q || out_ready_i;
  assign take    = load && !empty_i;
  assign is_last = (RUN_LW'(idx_q) == RUN_LW'(head_i.len - 1'b1));
  assign pop_o   = take && is_last;

  // Advance through the run and refill the output stage
  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = !empty_i;
    end
    if (take) begin
      idx_d = is_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Capture the payload of the next byte
  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= head_i.bytes[idx_q];
      disc_q <= head_i.discard && (idx_q == '0);
      last_q <= is_last;
    end
  end

  assign out_valid_o      = valid_q;
  assign out_byte_o       = byte_q;
  assign discard_before_o = disc_q;
  assign last_of_run_o    = last_q;

  `ASSERT_PROP(a_mid_run_has_head, clk_i, rst_ni, (idx_q != '0) |-> !empty_i, "run index without head")
  `ASSERT_PROP(a_discard_is_null, clk_i, rst_ni, (valid_q && disc_q) |-> (byte_q == 8'h6E), "discard not on null")

endmodule

@@ rtl/core/json_string_escaper.sv @@
// ----------------------------------------------------------------------------
// json_string_escaper
// Escapes decoded UTF-16 code units into a quoted JSON string, one byte out
// per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (item_kind_i, code_unit_i) arrive on a valid/ready channel:
//   a code unit, an end-of-string marker or a decode-error marker. Each
//   request yields a run of 1 to 7 bytes on the output valid/ready channel;
//   the unused kind is accepted and dropped without output.
//   last_of_run_o flags the final byte of a run and discard_before_o flags
//   the first byte of the "null" that replaces a string after an error.
//   The front end takes one request per cycle, while the queue has room, into
//   a two-entry queue; the back end emits one byte per cycle while the
//   receiver is ready, so a request holds the output until every byte of its
//   run (1, 2, 3, 4, 6 or 7) is taken. An accepted request is first written
//   into the queue, and its first byte is then loaded into the output stage.
//   escape_options sits at APB address 0 and should be written while idle.
//   Reset clears the options, the open-string flag, the queue and the
//   output stage. A stalled receiver holds the current byte; the queue then
//   fills and in_ready_o drops until bytes drain.
// ----------------------------------------------------------------------------
module json_string_escaper import jse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // Input requests
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         item_kind_i,
  input  logic [15:0]        code_unit_i,
  // Output bytes
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               discard_before_o,
  output logic               last_of_run_o
);

  logic [OPT_W-1:0] opts_q;
  logic             reg_idx;
  logic             q_full;
  logic             q_empty;
  logic             push;
  logic             pop;
  run_desc_t        push_desc;
  run_desc_t        head;

  // Register access
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1];
  assign prdata  = (reg_idx == REG_IDX_OPTS) ? PDATA_W'(opts_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opts_q <= '0;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_IDX_OPTS)) begin
      opts_q <= pwdata[OPT_W-1:0];
    end
  end

  jse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .opts_i      (opts_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .item_kind_i (item_kind_i),
    .code_unit_i (code_unit_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_desc_o (push_desc)
  );

  jse_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  jse_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (q_empty),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .discard_before_o (discard_before_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for json_string_escaper. A short table of directed
// requests covers the escape rules, the extremes of the code unit, empty
// strings, decode errors and the unused kind, then random strings run under
// a series of option settings and idle patterns. Every output byte is
// checked against an in-bench model of the escaper or a typed-in run.
// ----------------------------------------------------------------------------
module tb;
  import jse_pkg::*;

  localparam int unsigned LIMIT_CYCLES   = 200000;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned ITEMS_PER_SET  = 28;
  localparam int unsigned NUM_SETS       = 12;
  localparam int unsigned NUM_FIXED_SETS = 9;

  localparam logic [1:0]         KIND_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_OPTS   = PADDR_W'(4 * REG_IDX_OPTS);
  localparam logic [PADDR_W-1:0] ADDR_NONE   = PADDR_W'(4);

  // Characters with rules of their own
  localparam logic [15:0] U_BS     = 16'h0008;
  localparam logic [15:0] U_TAB    = 16'h0009;
  localparam logic [15:0] U_LF     = 16'h000A;
  localparam logic [15:0] U_FF     = 16'h000C;
  localparam logic [15:0] U_CR     = 16'h000D;
  localparam logic [15:0] U_QUOTE  = 16'h0022;
  localparam logic [15:0] U_PCT    = 16'h0025;
  localparam logic [15:0] U_AMP    = 16'h0026;
  localparam logic [15:0] U_APOS   = 16'h0027;
  localparam logic [15:0] U_SLASH  = 16'h002F;
  localparam logic [15:0] U_LT     = 16'h003C;
  localparam logic [15:0] U_GT     = 16'h003E;
  localparam logic [15:0] U_AT     = 16'h0040;
  localparam logic [15:0] U_BSLASH = 16'h005C;
  localparam logic [15:0] U_DEL    = 16'h007F;

  localparam logic [15:0] SPECIAL_UNITS [15] = '{
    U_BS, U_TAB, U_LF, U_FF, U_CR, U_QUOTE, U_PCT, U_AMP,
    U_APOS, U_SLASH, U_LT, U_GT, U_AT, U_BSLASH, U_DEL
  };

  localparam logic [OPT_W-1:0] OPT_PLAN [NUM_FIXED_SETS] = '{
    6'h00, 6'h3F, 6'h20, 6'h04, 6'h01, 6'h02, 6'h08, 6'h10, 6'h3F
  };

  localparam string HEX_DIGITS = "0123456789abcdef";

  typedef struct packed {
    logic [7:0] data;
    logic       discard;
    logic       last;
  } out_beat_t;

  // One directed request; a non-empty text is the typed-in expected run
  typedef struct {
    logic [OPT_W-1:0] opts;
    logic [1:0]       kind;
    logic [15:0]      code;
    string            text;
  } stim_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [1:0]         item_kind_i = 2'd0;
  logic [15:0]        code_unit_i = 16'd0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [7:0]         out_byte_o;
  logic               discard_before_o;
  logic               last_of_run_o;

  // Escaper model state
  logic [OPT_W-1:0] escape_opts = '0;
  logic             str_open    = 1'b0;
  logic [7:0]       run_q [$];
  logic             run_discard;

  out_beat_t   expected_bytes_q [$];
  stim_row_t   stim_rows [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned item_count    = 0;
  int unsigned byte_count    = 0;
  int unsigned set_count     = 0;
  int unsigned fail_count    = 0;

  json_string_escaper u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .item_kind_i      (item_kind_i),
    .code_unit_i      (code_unit_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .discard_before_o (discard_before_o),
    .last_of_run_o    (last_of_run_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      run_q.push_back(s[i]);
    end
  endfunction

  // Append the escaped form of one code unit to the run
  function automatic void escape_code(input logic [15:0] code);
    case (code)
      U_QUOTE: begin
        if (escape_opts[OPT_HEX_QUOT]) put_text("\\u0022");
        else put_text("\\\"");
      end
      U_BSLASH: put_text("\\\\");
      U_SLASH: begin
        if (escape_opts[OPT_NO_SLASH]) put_text("/");
        else put_text("\\/");
      end
      U_BS:  put_text("\\b");
      U_FF:  put_text("\\f");
      U_LF:  put_text("\\n");
      U_CR:  put_text("\\r");
      U_TAB: put_text("\\t");
      U_LT: begin
        if (escape_opts[OPT_HEX_TAG] || escape_opts[OPT_EXTRA]) put_text("\\u003C");
        else put_text("<");
      end
      U_GT: begin
        if (escape_opts[OPT_HEX_TAG]) put_text("\\u003E");
        else put_text(">");
      end
      U_AMP: begin
        if (escape_opts[OPT_HEX_AMP]) put_text("\\u0026");
        else put_text("&");
      end
      U_APOS: begin
        if (escape_opts[OPT_HEX_APOS]) put_text("\\u0027");
        else put_text("'");
      end
      U_AT: begin
        if (escape_opts[OPT_EXTRA]) put_text("\\u0040");
        else put_text("@");
      end
      U_PCT: begin
        if (escape_opts[OPT_EXTRA]) put_text("\\u0025");
        else put_text("%");
      end
      default: begin
        if (code >= 16'h0020 && code <= U_DEL) begin
          run_q.push_back(code[7:0]);
        end else begin
          put_text("\\u");
          run_q.push_back(HEX_DIGITS[code[15:12]]);
          run_q.push_back(HEX_DIGITS[code[11:8]]);
          run_q.push_back(HEX_DIGITS[code[7:4]]);
          run_q.push_back(HEX_DIGITS[code[3:0]]);
        end
      end
    endcase
  endfunction

  // Build the byte run one request causes and advance the open-string flag
  function automatic void predict_run(input logic [1:0] kind, input logic [15:0] code);
    run_q.delete();
    run_discard = 1'b0;
    case (kind)
      KIND_UNIT: begin
        if (!str_open) begin
          put_text("\"");
          str_open = 1'b1;
        end
        escape_code(code);
      end
      KIND_END: begin
        if (!str_open) put_text("\"");
        put_text("\"");
        str_open = 1'b0;
      end
      KIND_ERROR: begin
        put_text("null");
        run_discard = 1'b1;
        str_open    = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Read the options register back and compare with the model
  task automatic check_options();
    logic [PDATA_W-1:0] rd;
    apb_read(ADDR_OPTS, rd);
    if (rd !== PDATA_W'(escape_opts)) begin
      $error("escape_options readback: expected %h, actual %h", escape_opts, rd);
      fail_count++;
    end
  endtask

  task automatic set_options(input logic [OPT_W-1:0] value);
    apb_write(ADDR_OPTS, PDATA_W'(value));
    escape_opts = value;
    set_count++;
    check_options();
  endtask

  // Drive one request, hold it until accepted, then queue its bytes
  task automatic send_request(input logic [1:0] kind, input logic [15:0] code,
                              input string text);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    item_kind_i <= kind;
    code_unit_i <= code;
    do @(posedge clk_i); while (!in_ready_o);
    predict_run(kind, code);
    if (text.len() != 0) begin
      run_q.delete();
      put_text(text);
    end
    for (int i = 0; i < run_q.size(); i++) begin
      expected_bytes_q.push_back('{data:    run_q[i],
                                   discard: run_discard && (i == 0),
                                   last:    (i == run_q.size() - 1)});
    end
    if (kind != KIND_UNUSED) item_count++;
  endtask

  // Drop valid, drain all expected bytes, then let the pipeline settle
  task automatic drain_output();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] random_code();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return 16'($urandom_range(16'h20, 16'h7E));
    if (sel < 60) return SPECIAL_UNITS[$urandom_range(0, 14)];
    if (sel < 70) return 16'($urandom_range(0, 16'h1F));
    if (sel < 80) return 16'($urandom_range(16'h7F, 16'hFF));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // Send one string: units with random content, then mostly an end marker
  task automatic send_random_string();
    int unsigned len;
    int unsigned sel;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 5);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_request(KIND_UNUSED, 16'($urandom), "");
      send_request(KIND_UNIT, random_code(), "");
    end
    sel = $urandom_range(0, 99);
    if (sel < 75) send_request(KIND_END, 16'($urandom), "");
    else if (sel < 92) send_request(KIND_ERROR, 16'($urandom), "");
  endtask

  function automatic void add_row(input logic [OPT_W-1:0] opts, input logic [1:0] kind,
                                  input logic [15:0] code, input string text);
    stim_row_t row;
    row.opts = opts;
    row.kind = kind;
    row.code = code;
    row.text = text;
    stim_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------- checker

  task automatic check_output_byte();
    out_beat_t exp_beat;
    if (expected_bytes_q.size() == 0) begin
      $error("unexpected output byte %h", out_byte_o);
      fail_count++;
    end else begin
      exp_beat = expected_bytes_q.pop_front();
      byte_count++;
      if (out_byte_o !== exp_beat.data) begin
        $error("out_byte: expected %h, actual %h", exp_beat.data, out_byte_o);
        fail_count++;
      end
      if (discard_before_o !== exp_beat.discard) begin
        $error("discard_before: expected %b, actual %b", exp_beat.discard, discard_before_o);
        fail_count++;
      end
      if (last_of_run_o !== exp_beat.last) begin
        $error("last_of_run: expected %b, actual %b", exp_beat.last, last_of_run_o);
        fail_count++;
      end
    end
  endtask

  // Check accepted bytes and stall the receiver at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_output_byte();
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Abort a hung run
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("** json_string_escaper: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    logic [OPT_W-1:0] next_opts;
    int unsigned      target;

    // Default options first, checked against typed-in runs where obvious
    add_row(6'h00, KIND_UNIT,   16'h0041, "\"A");
    add_row(6'h00, KIND_UNIT,   16'h0000, "\\u0000");
    add_row(6'h00, KIND_UNIT,   16'hFFFF, "\\uffff");
    add_row(6'h00, KIND_UNIT,   U_QUOTE,  "\\\"");
    add_row(6'h00, KIND_UNIT,   U_BSLASH, "\\\\");
    add_row(6'h00, KIND_UNIT,   U_SLASH,  "\\/");
    add_row(6'h00, KIND_UNIT,   U_BS,     "");
    add_row(6'h00, KIND_UNIT,   U_FF,     "");
    add_row(6'h00, KIND_UNIT,   U_LF,     "");
    add_row(6'h00, KIND_UNIT,   U_CR,     "");
    add_row(6'h00, KIND_UNIT,   U_TAB,    "");
    add_row(6'h00, KIND_UNIT,   U_DEL,    "");
    add_row(6'h00, KIND_UNIT,   16'h0080, "");
    add_row(6'h00, KIND_UNIT,   U_LT,     "");
    add_row(6'h00, KIND_UNIT,   U_GT,     "");
    add_row(6'h00, KIND_UNIT,   U_AMP,    "");
    add_row(6'h00, KIND_UNIT,   U_APOS,   "");
    add_row(6'h00, KIND_UNIT,   U_AT,     "");
    add_row(6'h00, KIND_UNIT,   U_PCT,    "");
    add_row(6'h00, KIND_UNUSED, 16'h0041, "");
    add_row(6'h00, KIND_END,    16'h0000, "\"");
    // Empty string, then an error with no string open
    add_row(6'h00, KIND_END,    16'hFFFF, "\"\"");
    add_row(6'h00, KIND_ERROR,  16'h0000, "null");
    // All options set, then an error inside an open string
    add_row(6'h3F, KIND_UNIT,   U_QUOTE,  "");
    add_row(6'h3F, KIND_UNIT,   U_SLASH,  "");
    add_row(6'h3F, KIND_UNIT,   U_LT,     "");
    add_row(6'h3F, KIND_UNIT,   U_GT,     "");
    add_row(6'h3F, KIND_UNIT,   U_AMP,    "");
    add_row(6'h3F, KIND_UNIT,   U_APOS,   "");
    add_row(6'h3F, KIND_UNIT,   U_AT,     "");
    add_row(6'h3F, KIND_UNIT,   U_PCT,    "");
    add_row(6'h3F, KIND_ERROR,  16'hFFFF, "null");

    // Hold reset, then release it on a clock edge
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_options();

    // Walk the directed table, reprogramming only while idle
    send_idle_pct = 38;
    recv_idle_pct = 61;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].opts != escape_opts) begin
        drain_output();
        set_options(stim_rows[i].opts);
      end
      send_request(stim_rows[i].kind, stim_rows[i].code, stim_rows[i].text);
    end
    drain_output();

    // A write past the last register must leave the options alone
    apb_write(ADDR_NONE, PDATA_W'($urandom_range(0, 63)));
    check_options();

    // Random strings: three idle patterns, several option settings each
    for (int s = 0; s < NUM_SETS; s++) begin
      case (s / (NUM_SETS / 3))
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      next_opts = (s < NUM_FIXED_SETS) ? OPT_PLAN[s] : OPT_W'($urandom_range(0, 63));
      set_options(next_opts);
      target = item_count + ITEMS_PER_SET;
      while (item_count < target) send_random_string();
      drain_output();
    end

    $display("Ran %0d requests under %0d option writes; %0d output bytes checked.",
             item_count, set_count, byte_count);
    $display("Idle patterns: sender 38/receiver 61, sender 61/receiver 38, none.");
    if (fail_count == 0) begin
      $display("** json_string_escaper: PASSED **");
    end else begin
      $display("** json_string_escaper: FAILED **");
    end
    $finish;
  end

endmodule
